@@ sv/dcp_pkg.sv @@
package dcp_pkg;

  localparam int unsigned MAX_ENTRIES = 65535;
  localparam logic [15:0] COUNT_CAP =
    16'((MAX_ENTRIES < 65535) ? MAX_ENTRIES : 65535);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;

  // floor((2^63-1)/10) and floor((2^64-1)/10)
  localparam logic [63:0] LIM_SIGNED   = 64'd922337203685477580;
  localparam logic [63:0] LIM_UNSIGNED = 64'h1999999999999999;

  localparam logic KIND_FIELD   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic REG_SIGNED_MODE    = 1'b0;
  localparam logic REG_HEADER_PRESENT = 1'b1;

  localparam logic SIGNED_MODE_RESET    = 1'b1;
  localparam logic HEADER_PRESENT_RESET = 1'b1;

  localparam int RES_DEPTH = 4;
  localparam int RES_AW    = $clog2(RES_DEPTH);

  typedef struct packed {
    logic [7:0] char_byte;
    logic       byte_present;
    logic       field_end;
    logic       column_end;
  } chars_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] value;
    logic        field_ok;
    logic [15:0] entry_count;
    logic [63:0] min_value;
    logic [63:0] max_value;
    logic        column_ok;
    logic        last;
  } result_t;

  // closed-field or column-end event passed from the parse stage to the statistics stage
  typedef struct packed {
    logic        fld;
    logic        col;
    logic [63:0] v;
    logic        ok;
    logic        hdr_missing;
    logic        smode;
  } field_rec_t;

  function automatic logic less_than(input logic smode, input logic [63:0] a,
                                     input logic [63:0] b);
    logic [63:0] flip;
    flip = {smode, 63'b0};
    return (a ^ flip) < (b ^ flip);
  endfunction

endpackage

@@ sv/dcp_in_if.sv @@
interface dcp_in_if import dcp_pkg::*; ();
  logic   valid;
  logic   ready;
  chars_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/dcp_out_if.sv @@
interface dcp_out_if import dcp_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/decimal_column_parse_minmax.sv @@
// channel   dir  payload                                      transaction
// chars     in   char_byte, byte_present, field_end, col_end  valid & ready
// results   out  kind, value, field_ok, count, min, max, ok   valid & ready
// cfg       in   cfg_index, cfg_data                          cfg_we
//
// One character per cycle while the result side is not stalled.
// An item that closes both a field and the column yields two results, which
// a 4-entry result queue absorbs; they leave the result side one at a time.
// The digit accumulate loop (x10 shift-add with overflow check) is combinational.
// rst is synchronous; it clears control state and sets registers to defaults.
// A stall on results fills the queue, then holds each stage in place.
module decimal_column_parse_minmax import dcp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic      cfg_data,
  dcp_in_if.sink    chars,
  dcp_out_if.source results
);

  logic signed_mode;
  logic header_present;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode    <= SIGNED_MODE_RESET;
      header_present <= HEADER_PRESENT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIGNED_MODE:    signed_mode    <= cfg_data;
        REG_HEADER_PRESENT: header_present <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic   s1_valid;
  chars_t s1;
  logic   s1_ready;
  logic   s2_valid;
  logic   s2_ready;
  logic   take2;

  assign s1_ready    = !s1_valid || s2_ready;
  assign chars.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= chars.valid;
    end
    if (s1_ready && chars.valid) begin
      s1 <= chars.data;
    end
  end

  // parse stage
  logic [63:0] acc;
  logic        neg;
  logic [1:0]  nchars;
  logic        dseen;
  logic        fbad;
  logic        in_header;

  logic [63:0] acc_n;
  logic        neg_n;
  logic [1:0]  nchars_n;
  logic        dseen_n;
  logic        fbad_n;
  logic        in_header_n;

  logic        is_digit;
  logic        is_sign;
  logic        first;
  logic [3:0]  dig;
  logic [63:0] acc10;
  logic [64:0] usum;
  logic [63:0] mag;
  logic        ovf;
  logic [63:0] acc_dig;
  logic        close;
  field_rec_t  rec;
  logic        rec_valid;

  always_comb begin
    is_digit = (s1.char_byte >= CHAR_ZERO) && (s1.char_byte <= CHAR_NINE);
    is_sign  = (s1.char_byte == CHAR_MINUS) || (s1.char_byte == CHAR_PLUS);
    first    = (nchars == 2'd0);
    dig      = s1.char_byte[3:0];
    acc10    = {acc[60:0], 3'b000} + {acc[62:0], 1'b0};
    usum     = {1'b0, acc10} + {61'b0, dig};
    mag      = 64'd0 - acc;
    if (!signed_mode) begin
      ovf     = (acc > LIM_UNSIGNED) || usum[64];
      acc_dig = usum[63:0];
    end else if (!neg) begin
      ovf     = (acc > LIM_SIGNED) || ((acc == LIM_SIGNED) && (dig > 4'd7));
      acc_dig = usum[63:0];
    end else begin
      ovf     = (mag > LIM_SIGNED) || ((mag == LIM_SIGNED) && (dig > 4'd8));
      acc_dig = acc10 - {60'b0, dig};
    end

    acc_n       = acc;
    neg_n       = neg;
    nchars_n    = nchars;
    dseen_n     = dseen;
    fbad_n      = fbad;
    in_header_n = in_header;

    if (s1.byte_present) begin
      if (nchars != 2'd3) begin
        nchars_n = nchars + 2'd1;
      end
      if (!in_header) begin
        priority if (is_digit) begin
          dseen_n = 1'b1;
          if (!fbad) begin
            if (ovf) begin
              fbad_n = 1'b1;
            end else begin
              acc_n = acc_dig;
            end
          end
        end else if (first && signed_mode && is_sign) begin
          neg_n = (s1.char_byte == CHAR_MINUS);
        end else begin
          fbad_n = 1'b1;
        end
      end
    end

    close           = s1.field_end || (s1.column_end && (nchars_n != 2'd0));
    rec.fld         = 1'b0;
    rec.col         = 1'b0;
    rec.v           = '0;
    rec.ok          = 1'b0;
    rec.hdr_missing = 1'b0;
    rec.smode       = signed_mode;

    if (close) begin
      if (in_header) begin
        in_header_n = 1'b0;
      end else begin
        rec.fld = 1'b1;
        rec.ok  = !fbad_n && dseen_n;
        rec.v   = rec.ok ? acc_n : 64'd0;
      end
      acc_n    = '0;
      neg_n    = 1'b0;
      nchars_n = 2'd0;
      dseen_n  = 1'b0;
      fbad_n   = 1'b0;
    end
    if (s1.column_end) begin
      rec.col         = 1'b1;
      rec.hdr_missing = in_header_n;
      in_header_n     = header_present;
    end
    rec_valid = rec.fld || rec.col;
  end

  field_rec_t s2_rec;

  assign s2_ready = !s2_valid || take2;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      neg       <= 1'b0;
      nchars    <= 2'd0;
      dseen     <= 1'b0;
      fbad      <= 1'b0;
      in_header <= HEADER_PRESENT_RESET;
    end else if (s1_valid && s2_ready) begin
      acc       <= acc_n;
      neg       <= neg_n;
      nchars    <= nchars_n;
      dseen     <= dseen_n;
      fbad      <= fbad_n;
      in_header <= in_header_n;
    end
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid && rec_valid;
    end
    if (s2_ready) begin
      s2_rec <= rec;
    end
  end

  // statistics stage and result queue
  logic [15:0] field_counter;
  logic [63:0] run_min;
  logic [63:0] run_max;
  logic        column_bad;
  logic        good_seen;

  logic [15:0] cnt_n;
  logic [63:0] min_n;
  logic [63:0] max_n;
  logic        cbad_n;
  logic        gseen_n;
  result_t     res_field;
  result_t     res_sum;

  result_t            resq [RES_DEPTH];
  logic [RES_AW-1:0]  wp;
  logic [RES_AW-1:0]  rp;
  logic [RES_AW:0]    qcnt;
  logic [1:0]         npush;
  logic               pop;

  assign take2 = s2_valid && (qcnt <= (RES_AW + 1)'(RES_DEPTH - 2));
  assign pop   = results.valid && results.ready;
  assign npush = take2 ? ({1'b0, s2_rec.fld} + {1'b0, s2_rec.col}) : 2'd0;

  always_comb begin
    cnt_n   = field_counter;
    min_n   = run_min;
    max_n   = run_max;
    cbad_n  = column_bad;
    gseen_n = good_seen;
    if (s2_rec.fld) begin
      if (field_counter < COUNT_CAP) begin
        cnt_n = field_counter + 16'd1;
      end
      if (s2_rec.ok) begin
        if (!good_seen) begin
          min_n   = s2_rec.v;
          max_n   = s2_rec.v;
          gseen_n = 1'b1;
        end else begin
          if (less_than(s2_rec.smode, s2_rec.v, run_min)) begin
            min_n = s2_rec.v;
          end
          if (less_than(s2_rec.smode, run_max, s2_rec.v)) begin
            max_n = s2_rec.v;
          end
        end
      end else begin
        cbad_n = 1'b1;
      end
    end

    res_field             = '0;
    res_field.kind        = KIND_FIELD;
    res_field.value       = s2_rec.v;
    res_field.field_ok    = s2_rec.ok;
    res_field.last        = !s2_rec.col;

    res_sum               = '0;
    res_sum.kind          = KIND_SUMMARY;
    res_sum.entry_count   = cnt_n;
    res_sum.min_value     = min_n;
    res_sum.max_value     = max_n;
    res_sum.column_ok     = !cbad_n && !s2_rec.hdr_missing;
    res_sum.last          = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_counter <= '0;
      run_min       <= '0;
      run_max       <= '0;
      column_bad    <= 1'b0;
      good_seen     <= 1'b0;
    end else if (take2) begin
      if (s2_rec.col) begin
        field_counter <= '0;
        run_min       <= '0;
        run_max       <= '0;
        column_bad    <= 1'b0;
        good_seen     <= 1'b0;
      end else begin
        field_counter <= cnt_n;
        run_min       <= min_n;
        run_max       <= max_n;
        column_bad    <= cbad_n;
        good_seen     <= gseen_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take2) begin
      if (s2_rec.fld) begin
        resq[wp] <= res_field;
        if (s2_rec.col) begin
          resq[wp + RES_AW'(1)] <= res_sum;
        end
      end else if (s2_rec.col) begin
        resq[wp] <= res_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      qcnt <= '0;
    end else begin
      wp   <= wp + RES_AW'(npush);
      if (pop) begin
        rp <= rp + RES_AW'(1);
      end
      qcnt <= qcnt + (RES_AW + 1)'(npush) - (RES_AW + 1)'(pop);
    end
  end

  assign results.valid = (qcnt != '0);
  assign results.data  = resq[rp];

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qcnt <= (RES_AW + 1)'(RES_DEPTH))
    else $error("result queue overfilled");

  a_bad_field_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.data.kind == KIND_FIELD && !results.data.field_ok)
      |-> (results.data.value == 64'd0))
    else $error("bad field carries nonzero value");

  a_col_clear: assert property (@(posedge clk) disable iff (rst)
    (take2 && s2_rec.col) |=> (field_counter == '0 && !good_seen && !column_bad))
    else $error("column state not cleared after summary");

  a_empty_minmax: assert property (@(posedge clk) disable iff (rst)
    !good_seen |-> (run_min == '0 && run_max == '0))
    else $error("min or max set with no good value");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    field_counter <= COUNT_CAP)
    else $error("field counter past cap");

endmodule
